// ===== sv/lfu_pkg.sv =====
`timescale 1ns / 1ps

package lfu_pkg;

    // Field widths fixed by the interface
    localparam int ID_W       = 8;
    localparam int CFG_W      = 6;
    localparam int SLOT_IDX_W = 5;
    localparam int HITS_W     = 16;
    localparam int STAMP_W    = 32;

    // Default slot count and capacity register reset value
    localparam int               SLOTS_DEF = 32;
    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(32);

    // Saturation value of a hit count
    localparam logic [HITS_W-1:0] HITS_MAX = {HITS_W{1'b1}};

    // Result kinds
    localparam logic RK_STEP = 1'b0;
    localparam logic RK_LIST = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_REPORT,
        ST_LSCAN,
        ST_LEMIT
    } t_state;

endpackage

// ===== sv/lfu_slot_replacement_unit.sv =====
`timescale 1ns / 1ps

// Channel   | Handshake                   | Payload
// ----------+-----------------------------+-------------------------------------------
// request   | i_in_valid / o_in_ready     | i_candidate_id, i_last_item
// result    | o_out_valid / i_out_ready   | o_result_kind, o_hit, o_evicted_valid,
//           |                             | o_evicted_id, o_slot_index, o_listed_id,
//           |                             | o_last_result
// config    | i_cfg_we (no wait)          | i_cfg_data
//
// A request keeps o_in_ready low until it is finished: a pass over the slot memory read port
// finds the hit and the eviction victim, then an update step and a report step follow.
// A last request then lists held ids, each by a min-search pass and an emit step.
// Reset (i_rst_n low, synchronous) empties the slots and clears the sequence counter;
// slot contents need no clearing pass. A stalled result holds the sequencer at its next
// report; the request side opens again once the last result is in the output register.
module lfu_slot_replacement_unit #(
    parameter int SLOTS = lfu_pkg::SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [lfu_pkg::ID_W-1:0]     i_candidate_id,
    input  logic                         i_last_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_result_kind,
    output logic                         o_hit,
    output logic                         o_evicted_valid,
    output logic [lfu_pkg::ID_W-1:0]     o_evicted_id,
    output logic [lfu_pkg::SLOT_IDX_W-1:0] o_slot_index,
    output logic [lfu_pkg::ID_W-1:0]     o_listed_id,
    output logic                         o_last_result
);
    import lfu_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OCC_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;
    localparam logic [CMP_W-1:0] SLOTS_C = CMP_W'(SLOTS);
    localparam logic [CMP_W-1:0] ONE_C   = CMP_W'(1);

    // Slot memories
    logic [ID_W-1:0]    r_owner_mem [SLOTS];
    logic [HITS_W-1:0]  r_hits_mem  [SLOTS];
    logic [STAMP_W-1:0] r_stamp_mem [SLOTS];

    // Control state
    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_cap_cfg;
    logic [OCC_W-1:0]   r_occupied, n_occupied;
    logic [STAMP_W-1:0] r_seq, n_seq;
    logic [OCC_W-1:0]   r_idx, n_idx;
    logic [OCC_W-1:0]   r_lcount, n_lcount;
    logic               r_rd_ok;

    // Request and scan registers
    logic [ID_W-1:0]    r_id, n_id;
    logic               r_last, n_last;
    logic               r_hit, n_hit;
    logic [IDX_W-1:0]   r_slot, n_slot;
    logic [HITS_W-1:0]  r_hit_cnt, n_hit_cnt;
    logic               r_best_ok, n_best_ok;
    logic [IDX_W-1:0]   r_best_idx, n_best_idx;
    logic [HITS_W-1:0]  r_best_hits, n_best_hits;
    logic [STAMP_W-1:0] r_best_age, n_best_age;
    logic [ID_W-1:0]    r_best_owner, n_best_owner;
    logic               r_ev, n_ev;
    logic               r_min_ok, n_min_ok;
    logic [ID_W-1:0]    r_min, n_min;
    logic               r_prev_ok, n_prev_ok;
    logic [ID_W-1:0]    r_prev, n_prev;

    // Read stage
    logic [ID_W-1:0]    r_rd_owner;
    logic [HITS_W-1:0]  r_rd_hits;
    logic [STAMP_W-1:0] r_rd_stamp;
    logic [IDX_W-1:0]   r_rd_idx;

    // Output register
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_kind, n_out_kind;
    logic                  r_out_hit, n_out_hit;
    logic                  r_out_ev, n_out_ev;
    logic [ID_W-1:0]       r_out_evid, n_out_evid;
    logic [SLOT_IDX_W-1:0] r_out_slot, n_out_slot;
    logic [ID_W-1:0]       r_out_lid, n_out_lid;
    logic                  r_out_last, n_out_last;

    // Combinational helpers
    logic               w_issue;
    logic [IDX_W-1:0]   w_rd_addr;
    logic               w_scan_done;
    logic               w_out_free;
    logic [STAMP_W-1:0] w_age;
    logic [CMP_W-1:0]   w_cap;
    logic [CMP_W-1:0]   w_cfg_ext;
    logic               w_we_owner, w_we_hits, w_we_stamp;
    logic [IDX_W-1:0]   w_wr_addr;
    logic [HITS_W-1:0]  w_wr_hits;

    assign w_issue     = ((r_state == ST_SCAN) || (r_state == ST_LSCAN)) && (r_idx != r_occupied);
    assign w_rd_addr   = r_idx[IDX_W-1:0];
    assign w_scan_done = (r_idx == r_occupied) && !r_rd_ok;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_age       = r_seq - r_rd_stamp;
    assign w_cfg_ext   = CMP_W'(r_cap_cfg);

    // Clamp the configured capacity to 1..SLOTS
    always_comb begin
        if (w_cfg_ext < ONE_C) begin
            w_cap = ONE_C;
        end else if (w_cfg_ext > SLOTS_C) begin
            w_cap = SLOTS_C;
        end else begin
            w_cap = w_cfg_ext;
        end
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_out_kind;
    assign o_hit           = r_out_hit;
    assign o_evicted_valid = r_out_ev;
    assign o_evicted_id    = r_out_evid;
    assign o_slot_index    = r_out_slot;
    assign o_listed_id     = r_out_lid;
    assign o_last_result   = r_out_last;

    // Slot memories: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we_owner) begin
            r_owner_mem[w_wr_addr] <= r_id;
        end
        if (w_we_hits) begin
            r_hits_mem[w_wr_addr] <= w_wr_hits;
        end
        if (w_we_stamp) begin
            r_stamp_mem[w_wr_addr] <= r_seq;
        end
        r_rd_owner <= r_owner_mem[w_rd_addr];
        r_rd_hits  <= r_hits_mem[w_rd_addr];
        r_rd_stamp <= r_stamp_mem[w_rd_addr];
        r_rd_idx   <= w_rd_addr;
    end

    // Next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_occupied   = r_occupied;
        n_seq        = r_seq;
        n_idx        = r_idx;
        n_lcount     = r_lcount;
        n_id         = r_id;
        n_last       = r_last;
        n_hit        = r_hit;
        n_slot       = r_slot;
        n_hit_cnt    = r_hit_cnt;
        n_best_ok    = r_best_ok;
        n_best_idx   = r_best_idx;
        n_best_hits  = r_best_hits;
        n_best_age   = r_best_age;
        n_best_owner = r_best_owner;
        n_ev         = r_ev;
        n_min_ok     = r_min_ok;
        n_min        = r_min;
        n_prev_ok    = r_prev_ok;
        n_prev       = r_prev;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_kind   = r_out_kind;
        n_out_hit    = r_out_hit;
        n_out_ev     = r_out_ev;
        n_out_evid   = r_out_evid;
        n_out_slot   = r_out_slot;
        n_out_lid    = r_out_lid;
        n_out_last   = r_out_last;
        w_we_owner   = 1'b0;
        w_we_hits    = 1'b0;
        w_we_stamp   = 1'b0;
        w_wr_addr    = r_slot;
        w_wr_hits    = HITS_W'(1);

        if (w_issue) begin
            n_idx = r_idx + 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                // Latch the request and arm the scan
                if (i_in_valid) begin
                    n_id      = i_candidate_id;
                    n_last    = i_last_item;
                    n_idx     = '0;
                    n_hit     = 1'b0;
                    n_best_ok = 1'b0;
                    n_state   = ST_SCAN;
                end
            end

            ST_SCAN: begin
                // Track the first matching slot and the eviction victim
                if (r_rd_ok) begin
                    if (!r_hit && (r_rd_owner == r_id)) begin
                        n_hit     = 1'b1;
                        n_slot    = r_rd_idx;
                        n_hit_cnt = r_rd_hits;
                    end
                    if (!r_best_ok || (r_rd_hits < r_best_hits) ||
                        ((r_rd_hits == r_best_hits) && (w_age > r_best_age))) begin
                        n_best_ok    = 1'b1;
                        n_best_idx   = r_rd_idx;
                        n_best_hits  = r_rd_hits;
                        n_best_age   = w_age;
                        n_best_owner = r_rd_owner;
                    end
                end
                if (w_scan_done) begin
                    n_state = ST_UPDATE;
                end
            end

            ST_UPDATE: begin
                // Bump a hit, fill a free slot, or replace the victim
                n_ev = 1'b0;
                if (r_hit) begin
                    w_we_hits = 1'b1;
                    w_wr_hits = (r_hit_cnt == HITS_MAX) ? r_hit_cnt : r_hit_cnt + 1'b1;
                end else begin
                    if (CMP_W'(r_occupied) < w_cap) begin
                        n_slot     = IDX_W'(r_occupied);
                        w_wr_addr  = IDX_W'(r_occupied);
                        n_occupied = r_occupied + 1'b1;
                    end else begin
                        n_slot    = r_best_idx;
                        w_wr_addr = r_best_idx;
                        n_ev      = 1'b1;
                    end
                    w_we_owner = 1'b1;
                    w_we_hits  = 1'b1;
                    w_we_stamp = 1'b1;
                    n_seq      = r_seq + 1'b1;
                end
                n_state = ST_REPORT;
            end

            ST_REPORT: begin
                // Emit the step report, then list or finish
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = RK_STEP;
                    n_out_hit   = r_hit;
                    n_out_ev    = r_ev;
                    n_out_evid  = r_ev ? r_best_owner : '0;
                    n_out_slot  = SLOT_IDX_W'(r_slot);
                    n_out_lid   = '0;
                    n_out_last  = !r_last;
                    if (r_last) begin
                        n_idx     = '0;
                        n_lcount  = '0;
                        n_min_ok  = 1'b0;
                        n_prev_ok = 1'b0;
                        n_state   = ST_LSCAN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end

            ST_LSCAN: begin
                // Find the smallest held id above the last one listed
                if (r_rd_ok) begin
                    if ((!r_prev_ok || (r_rd_owner > r_prev)) &&
                        (!r_min_ok || (r_rd_owner < r_min))) begin
                        n_min_ok = 1'b1;
                        n_min    = r_rd_owner;
                    end
                end
                if (w_scan_done) begin
                    n_state = ST_LEMIT;
                end
            end

            ST_LEMIT: begin
                // Emit one listing entry, then advance to the next pass or return to idle
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = RK_LIST;
                    n_out_hit   = 1'b0;
                    n_out_ev    = 1'b0;
                    n_out_evid  = '0;
                    n_out_slot  = '0;
                    n_out_lid   = r_min;
                    n_out_last  = (OCC_W'(r_lcount + 1'b1) == r_occupied);
                    n_prev      = r_min;
                    n_prev_ok   = 1'b1;
                    n_lcount    = r_lcount + 1'b1;
                    n_min_ok    = 1'b0;
                    n_idx       = '0;
                    if (OCC_W'(r_lcount + 1'b1) == r_occupied) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_LSCAN;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap_cfg   <= CAP_RESET;
            r_occupied  <= '0;
            r_seq       <= '0;
            r_idx       <= '0;
            r_lcount    <= '0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_cap_cfg <= i_cfg_data;
            end
            r_occupied  <= n_occupied;
            r_seq       <= n_seq;
            r_idx       <= n_idx;
            r_lcount    <= n_lcount;
            r_rd_ok     <= w_issue;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_id         <= n_id;
        r_last       <= n_last;
        r_hit        <= n_hit;
        r_slot       <= n_slot;
        r_hit_cnt    <= n_hit_cnt;
        r_best_ok    <= n_best_ok;
        r_best_idx   <= n_best_idx;
        r_best_hits  <= n_best_hits;
        r_best_age   <= n_best_age;
        r_best_owner <= n_best_owner;
        r_ev         <= n_ev;
        r_min_ok     <= n_min_ok;
        r_min        <= n_min;
        r_prev_ok    <= n_prev_ok;
        r_prev       <= n_prev;
        r_out_kind   <= n_out_kind;
        r_out_hit    <= n_out_hit;
        r_out_ev     <= n_out_ev;
        r_out_evid   <= n_out_evid;
        r_out_slot   <= n_out_slot;
        r_out_lid    <= n_out_lid;
        r_out_last   <= n_out_last;
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import lfu_pkg::*;

    localparam int  CLK_HALF      = 5;
    localparam int  RESET_CYCLES  = 8;
    localparam int  CYCLE_LIMIT   = 3000000;
    localparam int  SETTLE_CYCLES = 6;
    localparam int  TAIL_CYCLES   = 80;
    localparam int  HOLD_CYCLES   = 300;
    localparam int  IDLE_PCT      = 33;
    localparam int  LIST_PCT      = 5;
    localparam int  HOT_PCT       = 70;
    localparam int  HOT_SPAN      = 40;
    localparam int  ROWS          = 25;
    localparam int  PHASES        = 5;

    // Random phases: capacity setting, request count, whether both sides idle
    localparam logic [CFG_W-1:0] PHASE_CAP [PHASES] = '{6'd32, 6'd5, 6'd63, 6'd0, 6'd1};
    localparam int               PHASE_REQS [PHASES] = '{130, 90, 60, 60, 60};
    localparam bit               PHASE_IDLES [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    typedef struct packed {
        logic                  kind;
        logic                  hit;
        logic                  evicted_valid;
        logic [ID_W-1:0]       evicted_id;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [ID_W-1:0]       listed_id;
        logic                  last_result;
    } t_slot_report;

    typedef enum logic {ROW_CFG, ROW_REQ} t_row_op;

    typedef struct packed {
        t_row_op          op;
        logic [CFG_W-1:0] cap;
        logic [ID_W-1:0]  id;
        logic             last;
        logic [16:0]      reps;
        logic             typed;
        t_slot_report     want;
    } t_directed_row;

    localparam t_slot_report NO_REPORT = '0;

    // DUT signals
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [ID_W-1:0]       i_candidate_id;
    logic                  i_last_item;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_result_kind;
    logic                  o_hit;
    logic                  o_evicted_valid;
    logic [ID_W-1:0]       o_evicted_id;
    logic [SLOT_IDX_W-1:0] o_slot_index;
    logic [ID_W-1:0]       o_listed_id;
    logic                  o_last_result;

    // Predictor state
    logic [ID_W-1:0]    held_id      [SLOTS_DEF];
    logic [HITS_W-1:0]  hit_count    [SLOTS_DEF];
    logic [STAMP_W-1:0] insert_stamp [SLOTS_DEF];
    int                 fill_count = 0;
    logic [STAMP_W-1:0] insert_seq = '0;
    logic [CFG_W-1:0]   capacity_reg = CAP_RESET;

    t_slot_report  pending_reports [$];
    t_directed_row directed_rows [ROWS];

    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    int mismatch_count = 0;
    int requests_sent  = 0;
    int results_seen   = 0;
    int hits_seen      = 0;
    int evictions_seen = 0;
    int listed_seen    = 0;
    int cycle_count    = 0;

    lfu_slot_replacement_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_candidate_id  (i_candidate_id),
        .i_last_item     (i_last_item),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_hit           (o_hit),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_id    (o_evicted_id),
        .o_slot_index    (o_slot_index),
        .o_listed_id     (o_listed_id),
        .o_last_result   (o_last_result)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Append one report to the tail of the pending list
    function automatic void queue_report(input t_slot_report rep);
        pending_reports.insert(pending_reports.size(), rep);
    endfunction

    // Update the slot store for one request and queue the reports it causes
    function automatic void predict_lookup(input logic [ID_W-1:0] id, input logic last_flag,
                                           input logic use_typed, input t_slot_report typed_rep);
        t_slot_report       rep;
        logic [ID_W-1:0]    sorted_ids [SLOTS_DEF];
        logic [ID_W-1:0]    v;
        logic [STAMP_W-1:0] age_k;
        logic [STAMP_W-1:0] age_v;
        int                 occ;
        int                 cap;
        int                 slot;
        int                 victim;
        int                 k;
        int                 j;
        bit                 found;

        rep   = NO_REPORT;
        occ   = fill_count;
        slot  = 0;
        found = 1'b0;
        cap   = (capacity_reg == 0) ? 1 :
                (capacity_reg > SLOTS_DEF) ? SLOTS_DEF : int'(capacity_reg);

        // Search the occupied slots for the id
        for (k = 0; k < occ; k++) begin
            if (!found && held_id[k] == id) begin
                found = 1'b1;
                slot  = k;
            end
        end

        if (found) begin
            if (hit_count[slot] != HITS_MAX) hit_count[slot]++;
        end else begin
            if (occ < cap) begin
                slot       = occ;
                fill_count = occ + 1;
            end else begin
                // Lowest count goes; among equal counts the oldest insertion
                victim = 0;
                for (k = 1; k < occ; k++) begin
                    age_k = insert_seq - insert_stamp[k];
                    age_v = insert_seq - insert_stamp[victim];
                    if (hit_count[k] < hit_count[victim] ||
                        (hit_count[k] == hit_count[victim] && age_k > age_v)) begin
                        victim = k;
                    end
                end
                slot              = victim;
                rep.evicted_valid = 1'b1;
                rep.evicted_id    = held_id[victim];
            end
            held_id[slot]      = id;
            hit_count[slot]    = 1;
            insert_stamp[slot] = insert_seq;
            insert_seq         = insert_seq + 1;
        end

        rep.kind        = RK_STEP;
        rep.hit         = found;
        rep.slot_index  = SLOT_IDX_W'(slot);
        rep.last_result = !last_flag;
        queue_report(use_typed ? typed_rep : rep);

        // List held ids in ascending order
        if (last_flag) begin
            for (k = 0; k < fill_count; k++) begin
                v = held_id[k];
                j = k;
                while (j > 0 && sorted_ids[j-1] > v) begin
                    sorted_ids[j] = sorted_ids[j-1];
                    j--;
                end
                sorted_ids[j] = v;
            end
            for (k = 0; k < fill_count; k++) begin
                rep             = NO_REPORT;
                rep.kind        = RK_LIST;
                rep.listed_id   = sorted_ids[k];
                rep.last_result = (k + 1 == fill_count);
                queue_report(rep);
            end
        end
    endfunction

    // Offer one request and return at the edge that accepts it
    task automatic send_request(input logic [ID_W-1:0] id, input logic last_flag,
                                input logic use_typed, input t_slot_report typed_rep);
        @(negedge i_clk);
        while (sender_idles && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        predict_lookup(id, last_flag, use_typed, typed_rep);
        i_in_valid     <= 1'b1;
        i_candidate_id <= id;
        i_last_item    <= last_flag;
        do @(posedge i_clk); while (!o_in_ready);
        requests_sent++;
    endtask

    // Drain all reports, then write the capacity register
    task automatic write_capacity(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        capacity_reg = value;
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (receiver_idles) begin
                i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Check each accepted result against the oldest pending report
    always @(posedge i_clk) begin
        t_slot_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (o_result_kind == RK_LIST) listed_seen++;
            if (o_hit) hits_seen++;
            if (o_evicted_valid) evictions_seen++;
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with nothing pending, expected none, got kind %0d",
                         $time, o_result_kind);
            end else begin
                want = pending_reports.pop_front();
                compare_field("result_kind", want.kind, o_result_kind);
                compare_field("hit", want.hit, o_hit);
                compare_field("evicted_valid", want.evicted_valid, o_evicted_valid);
                compare_field("evicted_id", want.evicted_id, o_evicted_id);
                compare_field("slot_index", want.slot_index, o_slot_index);
                compare_field("listed_id", want.listed_id, o_listed_id);
                compare_field("last_result", want.last_result, o_last_result);
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d reports pending",
                     cycle_count, pending_reports.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [ID_W-1:0] hot_base;
        logic [ID_W-1:0] id;
        logic            last_flag;
        int              p;
        int              n;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_candidate_id = '0;
        i_last_item    = 1'b0;

        // Directed rows: capacity extremes, eviction, counts, listing
        directed_rows[0]  = '{ROW_CFG, 6'd0, 8'h00, 1'b0, 17'd1, 1'b0, NO_REPORT};
        directed_rows[1]  = '{ROW_REQ, 6'd0, 8'h00, 1'b0, 17'd1, 1'b1,
                              '{RK_STEP, 1'b0, 1'b0, 8'h00, 5'd0, 8'h00, 1'b1}};
        directed_rows[2]  = '{ROW_REQ, 6'd0, 8'h00, 1'b0, 17'd1, 1'b1,
                              '{RK_STEP, 1'b1, 1'b0, 8'h00, 5'd0, 8'h00, 1'b1}};
        directed_rows[3]  = '{ROW_REQ, 6'd0, 8'hFF, 1'b0, 17'd1, 1'b1,
                              '{RK_STEP, 1'b0, 1'b1, 8'h00, 5'd0, 8'h00, 1'b1}};
        directed_rows[4]  = '{ROW_REQ, 6'd0, 8'hFF, 1'b1, 17'd1, 1'b1,
                              '{RK_STEP, 1'b1, 1'b0, 8'h00, 5'd0, 8'h00, 1'b0}};
        directed_rows[5]  = '{ROW_REQ, 6'd0, 8'hA5, 1'b0, 17'd1, 1'b1,
                              '{RK_STEP, 1'b0, 1'b1, 8'hFF, 5'd0, 8'h00, 1'b1}};
        // Raise the single count well above a fresh one
        directed_rows[6]  = '{ROW_REQ, 6'd0, 8'hA5, 1'b0, 17'd3, 1'b0, NO_REPORT};
        directed_rows[7]  = '{ROW_CFG, 6'd2, 8'h00, 1'b0, 17'd1, 1'b0, NO_REPORT};
        directed_rows[8]  = '{ROW_REQ, 6'd0, 8'h5A, 1'b0, 17'd1, 1'b1,
                              '{RK_STEP, 1'b0, 1'b0, 8'h00, 5'd1, 8'h00, 1'b1}};
        // The heavily used slot must survive against a fresh one
        directed_rows[9]  = '{ROW_REQ, 6'd0, 8'h3C, 1'b0, 17'd1, 1'b1,
                              '{RK_STEP, 1'b0, 1'b1, 8'h5A, 5'd1, 8'h00, 1'b1}};
        directed_rows[10] = '{ROW_REQ, 6'd0, 8'hC3, 1'b0, 17'd1, 1'b0, NO_REPORT};
        directed_rows[11] = '{ROW_CFG, 6'd63, 8'h00, 1'b0, 17'd1, 1'b0, NO_REPORT};
        for (n = 0; n < ID_W; n++) begin
            directed_rows[12 + n] = '{ROW_REQ, 6'd0, 8'(1 << n), 1'b0, 17'd1, 1'b0, NO_REPORT};
        end
        directed_rows[20] = '{ROW_REQ, 6'd0, 8'h01, 1'b1, 17'd1, 1'b0, NO_REPORT};
        // Capacity below occupancy: misses evict among all held slots
        directed_rows[21] = '{ROW_CFG, 6'd1, 8'h00, 1'b0, 17'd1, 1'b0, NO_REPORT};
        directed_rows[22] = '{ROW_REQ, 6'd0, 8'h77, 1'b0, 17'd1, 1'b0, NO_REPORT};
        directed_rows[23] = '{ROW_REQ, 6'd0, 8'h77, 1'b1, 17'd1, 1'b0, NO_REPORT};
        directed_rows[24] = '{ROW_CFG, 6'd32, 8'h00, 1'b0, 17'd1, 1'b0, NO_REPORT};

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed rows
        for (n = 0; n < ROWS; n++) begin
            if (directed_rows[n].op == ROW_CFG) begin
                write_capacity(directed_rows[n].cap);
            end else begin
                sender_idles   = (directed_rows[n].reps == 1);
                receiver_idles = (directed_rows[n].reps == 1);
                repeat (directed_rows[n].reps) begin
                    send_request(directed_rows[n].id, directed_rows[n].last,
                                 directed_rows[n].typed, directed_rows[n].want);
                end
            end
        end

        // Random requests: mostly a hot set of ids so hits and evictions mix
        for (p = 0; p < PHASES; p++) begin
            write_capacity(PHASE_CAP[p]);
            sender_idles   = PHASE_IDLES[p];
            receiver_idles = PHASE_IDLES[p];
            hot_base       = ID_W'($urandom_range(255));
            for (n = 0; n < PHASE_REQS[p]; n++) begin
                if (p == 0 && n == 40) hold_requests++;
                if ($urandom_range(99) < HOT_PCT) begin
                    id = hot_base + ID_W'($urandom_range(HOT_SPAN - 1));
                end else begin
                    id = ID_W'($urandom_range(255));
                end
                last_flag = ($urandom_range(99) < LIST_PCT);
                send_request(id, last_flag, 1'b0, NO_REPORT);
            end
        end

        // Drain and let any stray result show up
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests over %0d capacity settings, %0d results checked",
                 requests_sent, PHASES + 5, results_seen);
        $display("Saw %0d hits, %0d evictions, %0d listing entries, %0d mismatches",
                 hits_seen, evictions_seen, listed_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
